>>> src/sorted_key_index_table_core_defines.svh
// assertion macros for the sorted key index table
`ifndef SORTED_KEY_INDEX_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_INDEX_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SKIT_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sorted key index table check failed");

// next-cycle implication, checked outside reset
`define SKIT_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sorted key index table check failed");

`endif

>>> src/skit_pkg.sv
// types, codes and constants shared by the sorted key index table
`timescale 1ns / 1ps
package skit_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_BYTES    = 5;
  localparam int unsigned KEY_W        = 8 * KEY_BYTES;
  localparam int unsigned REC_W        = 16;

  // port field widths
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned KEY_FIELD_W  = 40;
  localparam int unsigned REC_FIELD_W  = 16;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 7;

  // operation codes, code three acts as lookup
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [KEY_FIELD_W-1:0] key;
    logic [REC_FIELD_W-1:0] record_number;
  } skit_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [REC_FIELD_W-1:0] found_record;
    logic [COUNT_W-1:0]     entry_count;
  } skit_res_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] rec;
  } skit_entry_t;

  typedef struct packed {
    logic      fin;
    skit_res_t res;
  } skit_fin_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_PLACE
  } skit_state_e;

endpackage

>>> src/skit_store.sv
// table memory: one write port, one registered read port
`timescale 1ns / 1ps
module skit_store #(
  parameter int unsigned Depth = skit_pkg::CAPACITY_DEF,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  skit_pkg::skit_entry_t wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output skit_pkg::skit_entry_t rdata_o
);

  skit_pkg::skit_entry_t mem_q [Depth];
  skit_pkg::skit_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/skit_seq.sv
// sequencer with the shared key comparator: search, shift and place
`timescale 1ns / 1ps
module skit_seq #(
  parameter int unsigned Capacity = skit_pkg::CAPACITY_DEF,
  parameter int unsigned AddrW    = $clog2(Capacity),
  parameter int unsigned CountW   = $clog2(Capacity + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  skit_pkg::skit_cmd_t   cmd_i,
  input  skit_pkg::skit_entry_t rdata_i,
  output logic                  busy_o,
  output logic                  we_o,
  output logic [AddrW-1:0]      waddr_o,
  output skit_pkg::skit_entry_t wdata_o,
  output logic [AddrW-1:0]      raddr_o,
  output skit_pkg::skit_fin_t   fin_o
);

  skit_pkg::skit_state_e state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] pos_q, pos_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [skit_pkg::MODE_W-1:0] mode_q;
  logic [skit_pkg::KEY_W-1:0]  key_q;
  logic [skit_pkg::REC_W-1:0]  rec_q;

  logic start_acc;
  logic cmp_lt, cmp_eq, hit, at_end, resolve, full, last, is_ins, is_rem;
  logic [CountW-1:0] pos_inc, sel_pos, sel_p1, cnt_m1;
  logic [CountW-1:0] idx_m1, idx_m2, idx_p1, idx_p2;

  // shared comparator and decision terms
  always_comb begin
    start_acc = start_i && (state_q == skit_pkg::ST_IDLE);
    cmp_lt    = rdata_i.key < key_q;
    cmp_eq    = rdata_i.key == key_q;
    hit       = !cmp_lt && cmp_eq;
    pos_inc   = pos_q + CountW'(1);
    at_end    = pos_inc == cnt_q;
    sel_pos   = cmp_lt ? cnt_q : pos_q;
    sel_p1    = sel_pos + CountW'(1);
    cnt_m1    = cnt_q - CountW'(1);
    idx_m1    = idx_q - CountW'(1);
    idx_m2    = idx_q - CountW'(2);
    idx_p1    = idx_q + CountW'(1);
    idx_p2    = idx_q + CountW'(2);
    full      = cnt_q == CountW'(Capacity);
    last      = sel_p1 == cnt_q;
    is_ins    = mode_q == skit_pkg::MODE_INSERT;
    is_rem    = mode_q == skit_pkg::MODE_REMOVE;
    resolve   = (state_q == skit_pkg::ST_SEARCH) && !(cmp_lt && !at_end);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      skit_pkg::ST_IDLE: begin
        if (start_acc) begin
          if (cnt_q == '0) begin
            state_d = (cmd_i.mode == skit_pkg::MODE_INSERT) ? skit_pkg::ST_PLACE
                                                             : skit_pkg::ST_IDLE;
          end else begin
            state_d = skit_pkg::ST_SEARCH;
          end
        end
      end
      skit_pkg::ST_SEARCH: begin
        if (resolve) begin
          state_d = skit_pkg::ST_IDLE;
          if (is_ins) begin
            if (!hit && !full) begin
              state_d = (sel_pos == cnt_q) ? skit_pkg::ST_PLACE : skit_pkg::ST_SHIFT_UP;
            end
          end else if (is_rem) begin
            if (hit && !last) begin
              state_d = skit_pkg::ST_SHIFT_DN;
            end
          end
        end
      end
      skit_pkg::ST_SHIFT_UP: begin
        if (idx_m1 == pos_q) begin
          state_d = skit_pkg::ST_PLACE;
        end
      end
      skit_pkg::ST_SHIFT_DN: begin
        if (idx_p2 == cnt_q) begin
          state_d = skit_pkg::ST_IDLE;
        end
      end
      skit_pkg::ST_PLACE: begin
        state_d = skit_pkg::ST_IDLE;
      end
      default: begin
        state_d = skit_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath control, memory ports and result
  always_comb begin
    cnt_d                  = cnt_q;
    pos_d                  = pos_q;
    idx_d                  = idx_q;
    we_o                   = 1'b0;
    waddr_o                = idx_q[AddrW-1:0];
    wdata_o                = rdata_i;
    raddr_o                = '0;
    fin_o.fin              = 1'b0;
    fin_o.res.status       = skit_pkg::STATUS_OK;
    fin_o.res.found_record = '0;
    case (state_q)
      skit_pkg::ST_IDLE: begin
        if (start_acc) begin
          pos_d = '0;
          if ((cnt_q == '0) && (cmd_i.mode != skit_pkg::MODE_INSERT)) begin
            fin_o.fin        = 1'b1;
            fin_o.res.status = skit_pkg::STATUS_NOT_FOUND;
          end
        end
      end
      skit_pkg::ST_SEARCH: begin
        if (!resolve) begin
          pos_d   = pos_inc;
          raddr_o = pos_inc[AddrW-1:0];
        end else begin
          pos_d = sel_pos;
          if (is_ins) begin
            if (hit) begin
              fin_o.fin        = 1'b1;
              fin_o.res.status = skit_pkg::STATUS_DUPLICATE;
            end else if (full) begin
              fin_o.fin        = 1'b1;
              fin_o.res.status = skit_pkg::STATUS_FULL;
            end else begin
              idx_d   = cnt_q;
              raddr_o = cnt_m1[AddrW-1:0];
            end
          end else if (is_rem) begin
            if (!hit) begin
              fin_o.fin        = 1'b1;
              fin_o.res.status = skit_pkg::STATUS_NOT_FOUND;
            end else if (last) begin
              fin_o.fin = 1'b1;
              cnt_d     = cnt_m1;
            end else begin
              idx_d   = sel_pos;
              raddr_o = sel_p1[AddrW-1:0];
            end
          end else begin
            fin_o.fin = 1'b1;
            if (!hit) begin
              fin_o.res.status = skit_pkg::STATUS_NOT_FOUND;
            end else begin
              fin_o.res.found_record = skit_pkg::REC_FIELD_W'(rdata_i.rec);
            end
          end
        end
      end
      skit_pkg::ST_SHIFT_UP: begin
        we_o    = 1'b1;
        idx_d   = idx_m1;
        raddr_o = idx_m2[AddrW-1:0];
      end
      skit_pkg::ST_SHIFT_DN: begin
        we_o    = 1'b1;
        idx_d   = idx_p1;
        raddr_o = idx_p2[AddrW-1:0];
        if (idx_p2 == cnt_q) begin
          fin_o.fin = 1'b1;
          cnt_d     = cnt_m1;
        end
      end
      skit_pkg::ST_PLACE: begin
        we_o        = 1'b1;
        waddr_o     = pos_q[AddrW-1:0];
        wdata_o.key = key_q;
        wdata_o.rec = rec_q;
        fin_o.fin   = 1'b1;
        cnt_d       = cnt_q + CountW'(1);
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
    fin_o.res.entry_count = skit_pkg::COUNT_W'(cnt_d);
  end

  assign busy_o = state_q != skit_pkg::ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skit_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    idx_q <= idx_d;
    if (start_acc) begin
      mode_q <= cmd_i.mode;
      key_q  <= cmd_i.key[skit_pkg::KEY_W-1:0];
      rec_q  <= cmd_i.record_number[skit_pkg::REC_W-1:0];
    end
  end

endmodule

>>> src/sorted_key_index_table_core.sv
// top level of the sorted key index table
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+--------------------------------------
//   command  | start_i, cmd_i        | taken when start_i is high, busy_o low
//   result   | done_o, res_o         | one-cycle strobe, cannot be held off
//
// an item is taken in the idle state, then comes the key search (one table
// entry a cycle, up to the first entry not below the key), on insert or
// remove a move of the entries behind it one at a time, and on insert a last
// step to place the new entry; the pace is set by the single read port of the
// table memory
// the result is registered and shows in the cycle after the last step; a new
// item may be taken in that same cycle
// reset empties the table at once through the entry count, no clearing pass
`timescale 1ns / 1ps
`include "sorted_key_index_table_core_defines.svh"
module sorted_key_index_table_core #(
  parameter int unsigned Capacity = skit_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  skit_pkg::skit_cmd_t cmd_i,
  output logic                busy_o,
  output logic                done_o,
  output skit_pkg::skit_res_t res_o
);

  localparam int unsigned AddrW   = $clog2(Capacity);
  localparam int unsigned CountW  = $clog2(Capacity + 1);
  localparam int unsigned CntOutW = skit_pkg::COUNT_W;

  // memory port between sequencer and table
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [AddrW-1:0]      mem_raddr;
  skit_pkg::skit_entry_t mem_wdata;
  skit_pkg::skit_entry_t mem_rdata;

  // finishing step of the current item
  skit_pkg::skit_fin_t   fin;

  // output register, parts the sequencer from the result port
  logic                  done_q;
  skit_pkg::skit_res_t   res_q;

  skit_seq #(
    .Capacity (Capacity),
    .AddrW    (AddrW),
    .CountW   (CountW)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .rdata_i (mem_rdata),
    .busy_o  (busy_o),
    .we_o    (mem_we),
    .waddr_o (mem_waddr),
    .wdata_o (mem_wdata),
    .raddr_o (mem_raddr),
    .fin_o   (fin)
  );

  // key and record number side by side, kept in ascending key order
  skit_store #(
    .Depth (Capacity),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.fin;
    end
  end

  // result payload, loaded only when an item finishes
  always_ff @(posedge clk_i) begin
    if (fin.fin) begin
      res_q <= fin.res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // an accepted item either finishes at once or keeps the block busy
  `SKIT_ASSERT_NEXT(a_accept_progress, start_i && !busy_o, busy_o || done_o)
  // only a successful lookup reports a record number
  `SKIT_ASSERT_IMPL(a_miss_no_record, done_o && (res_o.status != skit_pkg::STATUS_OK), res_o.found_record == '0)
  // an insert refused as full only happens with the table full
  `SKIT_ASSERT_IMPL(a_full_count, done_o && (res_o.status == skit_pkg::STATUS_FULL), res_o.entry_count == CntOutW'(Capacity))

endmodule

>>> tb/tb.sv
// self-checking testbench for the sorted key index table core
`timescale 1ns / 1ps
module tb;
  import skit_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;

  // code three is not an operation of its own, the block decodes it as lookup
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic [KEY_FIELD_W-1:0] KEY_MIN = '0;
  localparam logic [KEY_FIELD_W-1:0] KEY_MAX = '1;
  // "ABCDE", a mid-range key with close neighbours either side
  localparam logic [KEY_FIELD_W-1:0] KEY_MID = 40'h41_42_43_44_45;

  localparam int RANDOM_ITEMS = 2000;
  localparam int POOL_SIZE    = 96;
  localparam int N_PROBES     = 15;
  // cycles with no item moving in either direction before the run is abandoned;
  // well above the slowest item plus the longest sender gap
  localparam int STALL_LIMIT  = 4000;
  // quiet time after the last result, long enough for one worst-case item
  localparam int DRAIN_CYCLES = 2 * CAP + 20;

  typedef struct {
    skit_cmd_t cmd;
    bit        typed;  // expectation written out below rather than predicted
    skit_res_t res;
  } probe_row_t;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      start_i = 1'b0;
  skit_cmd_t cmd_i   = '0;
  logic      busy_o;
  logic      done_o;
  skit_res_t res_o;

  // shadow copy of the table, kept sorted ascending by key
  logic [KEY_FIELD_W-1:0] idx_keys [CAP];
  logic [REC_FIELD_W-1:0] idx_recs [CAP];
  int unsigned            idx_fill = 0;

  skit_res_t due_results_q [$];
  bit        cmd_taken     = 1'b0;
  bit        use_typed     = 1'b0;
  skit_res_t typed_res     = '0;
  int        err_cnt       = 0;
  int        idle_cycles   = 0;

  logic [KEY_FIELD_W-1:0] key_pool [POOL_SIZE];
  probe_row_t             probe_rows [N_PROBES];

  sorted_key_index_table_core #(
    .Capacity (CAP)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // applies one operation to the shadow table and returns what the block should answer
  function automatic skit_res_t index_apply(input skit_cmd_t c);
    int unsigned pos;
    bit          hit;
    skit_res_t   r;
    pos = 0;
    // linear search for the first entry not below the key
    while (pos < idx_fill && idx_keys[pos] < c.key) pos++;
    hit = (pos < idx_fill) && (idx_keys[pos] == c.key);
    r   = '0;
    r.status = STATUS_OK;
    case (c.mode)
      MODE_INSERT: begin
        // a present key counts as duplicate even when the table is full
        if (hit) begin
          r.status = STATUS_DUPLICATE;
        end else if (idx_fill >= CAP) begin
          r.status = STATUS_FULL;
        end else begin
          for (int unsigned j = idx_fill; j > pos; j--) begin
            idx_keys[j] = idx_keys[j-1];
            idx_recs[j] = idx_recs[j-1];
          end
          idx_keys[pos] = c.key;
          idx_recs[pos] = c.record_number;
          idx_fill++;
        end
      end
      MODE_REMOVE: begin
        if (!hit) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          for (int unsigned j = pos; j + 1 < idx_fill; j++) begin
            idx_keys[j] = idx_keys[j+1];
            idx_recs[j] = idx_recs[j+1];
          end
          idx_fill--;
        end
      end
      default: begin
        // lookup, and the spare code behaves the same; a miss answers zero
        if (!hit) r.status = STATUS_NOT_FOUND;
        else      r.found_record = idx_recs[pos];
      end
    endcase
    r.entry_count = idx_fill[COUNT_W-1:0];
    return r;
  endfunction

  // everything sampled at the rising edge: results first, then the item taken
  // at this edge, then the stall watchdog
  always @(posedge clk_i) begin : sample
    skit_res_t want;
    skit_res_t predicted;
    if (rst_ni) begin
      if (done_o) begin
        if (due_results_q.size() == 0) begin
          $error("result with no item outstanding: status %0d found %0h count %0d",
                 res_o.status, res_o.found_record, res_o.entry_count);
          err_cnt++;
        end else begin
          want = due_results_q.pop_front();
          if (res_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_o.status);
            err_cnt++;
          end
          if (res_o.found_record !== want.found_record) begin
            $error("found_record: expected %0h, got %0h", want.found_record,
                   res_o.found_record);
            err_cnt++;
          end
          if (res_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   res_o.entry_count);
            err_cnt++;
          end
        end
      end

      cmd_taken = start_i && !busy_o;
      if (cmd_taken) begin
        // the shadow table moves on every item, typed rows included
        predicted = index_apply(cmd_i);
        due_results_q.push_back(use_typed ? typed_res : predicted);
      end

      if (cmd_taken || done_o) idle_cycles = 0;
      else                     idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // presents one item after an optional gap and holds it until taken;
  // start is left high after it is taken, so a back-to-back item follows with no low gap
  task automatic issue_cmd(input skit_cmd_t c, input int gap, input bit typed,
                           input skit_res_t typed_val);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    use_typed = typed;
    typed_res = typed_val;
    cmd_i   <= c;
    start_i <= 1'b1;
    do @(negedge clk_i); while (!cmd_taken);
  endtask

  initial begin : stimulus
    skit_cmd_t   c;
    int          items_sent;
    int unsigned phase;
    int unsigned run_len;
    int unsigned dice;
    bit          no_gaps;

    // key pool: runs of neighbouring keys so that misses land between entries,
    // more keys than the table holds so that it can fill and overflow
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 4 == 0) key_pool[i] = {8'($urandom_range(255, 0)), 32'($urandom())};
      else            key_pool[i] = key_pool[i-1] + 40'($urandom_range(3, 1));
    end
    key_pool[0]           = KEY_MIN;
    key_pool[POOL_SIZE-1] = KEY_MAX;

    // directed rows: empty table, both key extremes, duplicate, spare code,
    // a miss between two entries, removal at either end
    probe_rows = '{
      '{'{MODE_LOOKUP, KEY_MIN, 16'h0000}, 1'b1, '{STATUS_NOT_FOUND, 16'h0000, 7'd0}},
      '{'{MODE_REMOVE, KEY_MAX, 16'hffff}, 1'b1, '{STATUS_NOT_FOUND, 16'h0000, 7'd0}},
      '{'{MODE_INSERT, KEY_MIN, 16'hffff}, 1'b1, '{STATUS_OK, 16'h0000, 7'd1}},
      '{'{MODE_INSERT, KEY_MAX, 16'h8001}, 1'b1, '{STATUS_OK, 16'h0000, 7'd2}},
      '{'{MODE_INSERT, KEY_MIN, 16'h1234}, 1'b1, '{STATUS_DUPLICATE, 16'h0000, 7'd2}},
      '{'{MODE_LOOKUP, KEY_MIN, 16'h0000}, 1'b1, '{STATUS_OK, 16'hffff, 7'd2}},
      '{'{MODE_SPARE,  KEY_MAX, 16'h0000}, 1'b1, '{STATUS_OK, 16'h8001, 7'd2}},
      '{'{MODE_INSERT, KEY_MID, 16'h5555}, 1'b0, '{STATUS_OK, 16'h0000, 7'd0}},
      '{'{MODE_INSERT, KEY_MID - 40'd1, 16'haaaa}, 1'b0, '{STATUS_OK, 16'h0000, 7'd0}},
      '{'{MODE_LOOKUP, KEY_MID + 40'd1, 16'h0000}, 1'b0, '{STATUS_OK, 16'h0000, 7'd0}},
      '{'{MODE_REMOVE, KEY_MID, 16'h0000}, 1'b1, '{STATUS_OK, 16'h0000, 7'd3}},
      '{'{MODE_REMOVE, KEY_MID, 16'h0000}, 1'b1, '{STATUS_NOT_FOUND, 16'h0000, 7'd3}},
      '{'{MODE_LOOKUP, KEY_MID - 40'd1, 16'h0000}, 1'b1, '{STATUS_OK, 16'haaaa, 7'd3}},
      '{'{MODE_REMOVE, KEY_MIN, 16'h0000}, 1'b1, '{STATUS_OK, 16'h0000, 7'd2}},
      '{'{MODE_REMOVE, KEY_MAX, 16'h0000}, 1'b1, '{STATUS_OK, 16'h0000, 7'd1}}
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (probe_rows[i]) begin
      issue_cmd(probe_rows[i].cmd, $urandom_range(17, 0), probe_rows[i].typed,
                probe_rows[i].res);
    end

    // random part in runs: fill-heavy, drain-heavy, mixed, lookup-heavy;
    // some runs go back to back with no sender gaps at all
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      phase   = $urandom_range(3, 0);
      run_len = $urandom_range(90, 20);
      no_gaps = ($urandom_range(3, 0) == 0);
      repeat (run_len) begin
        dice = $urandom_range(99, 0);
        case (phase)
          0:       c.mode = (dice < 85) ? MODE_INSERT : MODE_LOOKUP;
          1:       c.mode = (dice < 75) ? MODE_REMOVE :
                            (dice < 90) ? MODE_LOOKUP : MODE_INSERT;
          2: begin
            case ($urandom_range(3, 0))
              0:       c.mode = MODE_INSERT;
              1:       c.mode = MODE_REMOVE;
              2:       c.mode = MODE_LOOKUP;
              default: c.mode = MODE_SPARE;
            endcase
          end
          default: c.mode = (dice < 45) ? MODE_LOOKUP :
                            (dice < 60) ? MODE_SPARE  :
                            (dice < 80) ? MODE_INSERT : MODE_REMOVE;
        endcase

        // keys: pool for frequent hits and near misses, entries now held,
        // and wholly random keys for the far corners of the key space
        dice = $urandom_range(99, 0);
        if (dice < 75 && (dice < 45 || idx_fill == 0))
          c.key = key_pool[$urandom_range(POOL_SIZE - 1, 0)];
        else if (dice < 75)
          c.key = idx_keys[$urandom_range(idx_fill - 1, 0)];
        else
          c.key = {8'($urandom_range(255, 0)), 32'($urandom())};

        c.record_number = 16'($urandom_range(16'hffff, 0));
        issue_cmd(c, no_gaps ? 0 : $urandom_range(17, 0), 1'b0, '0);
        items_sent++;
      end
    end
    start_i <= 1'b0;

    while (due_results_q.size() != 0) @(negedge clk_i);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
